FILE: rtl/shadow_framebuffer_change_writer_assert.svh
// Assertion macros for the shadow framebuffer change writer.
// Define NO_ASSERTIONS to compile every use to nothing.
`ifndef SHADOW_FRAMEBUFFER_CHANGE_WRITER_ASSERT_SVH
`define SHADOW_FRAMEBUFFER_CHANGE_WRITER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SFCW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define SFCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SFCW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SFCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/sfcw_pkg.sv
// Shared types and constants for the shadow framebuffer change writer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sfcw_pkg;

  localparam logic [1:0] OP_REPLACE = 2'd0;
  localparam logic [1:0] OP_OR      = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [7:0] CMD_COL_LO  = 8'h00;
  localparam logic [7:0] CMD_COL_HI  = 8'h10;
  localparam logic [7:0] CMD_PAGE    = 8'hB0;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;
  localparam logic [7:0] RAM_INIT    = 8'h01;

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] column;
    logic [2:0] page;
    logic [7:0] pixel_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } out_t;

  typedef enum logic [1:0] {
    BEAT_COL_LO = 2'd0,
    BEAT_COL_HI = 2'd1,
    BEAT_PAGE   = 2'd2,
    BEAT_DATA   = 2'd3
  } beat_t;

  typedef struct packed {
    logic  capture;
    logic  clr_step;
    logic  commit;
    beat_t beat;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic changed;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/sfcw_dp.sv
// Datapath: shadow RAM, item registers, clear sweep counter, byte formatting.
// Depends on sfcw_pkg; driven by sfcw_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module sfcw_dp #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sfcw_pkg::in_t      in_data,
  input  sfcw_pkg::ctl_cmd_t cmd,
  output sfcw_pkg::dp_stat_t stat,
  output sfcw_pkg::out_t     out_data
);
  import sfcw_pkg::*;

  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]    mem [DEPTH];
  in_t           item_r;
  logic [AW-1:0] idx_r;
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] clr_addr_nxt;
  logic [AW-1:0] wr_addr;
  logic [7:0]    old_r;
  logic [7:0]    new_r;
  logic [7:0]    next_byte;
  logic [7:0]    wr_data;
  logic          wr_en;
  logic          op_ok;
  logic          in_range;

  assign rd_idx = AW'(in_data.page) * AW'(COLUMNS) + AW'(in_data.column);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
      idx_r  <= rd_idx;
    end
    if (cmd.commit) begin
      new_r <= next_byte;
    end
  end

  // single-port shadow RAM, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.capture) begin
      old_r <= mem[rd_idx];
    end
  end

  assign clr_addr_nxt = clr_addr_r + AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_comb begin
    op_ok     = 1'b1;
    next_byte = old_r;
    unique case (item_r.command)
      OP_REPLACE: next_byte = item_r.pixel_byte;
      OP_OR:      next_byte = old_r | item_r.pixel_byte;
      OP_CLEAR:   next_byte = 8'h00;
      default:    op_ok     = 1'b0;
    endcase
  end

  assign in_range = ({1'b0, item_r.column} < 8'(COLUMNS)) &&
                    ({1'b0, item_r.page} < 4'(PAGES));

  assign stat.changed  = in_range && op_ok && (next_byte != old_r);
  assign stat.clr_last = (clr_addr_r == AW'(DEPTH - 1));

  assign wr_en   = cmd.clr_step | cmd.commit;
  assign wr_addr = cmd.clr_step ? clr_addr_r : idx_r;
  assign wr_data = cmd.clr_step ? RAM_INIT : next_byte;

  always_comb begin
    out_data.out_byte = new_r;
    out_data.is_data  = (cmd.beat == BEAT_DATA);
    out_data.last     = (cmd.beat == BEAT_DATA);
    unique case (cmd.beat)
      BEAT_COL_LO: out_data.out_byte = CMD_COL_LO + ({1'b0, item_r.column} & NIBBLE_MASK);
      BEAT_COL_HI: out_data.out_byte = CMD_COL_HI +
                                       (({1'b0, item_r.column} >> 4) & NIBBLE_MASK);
      BEAT_PAGE:   out_data.out_byte = CMD_PAGE + {5'b0, item_r.page};
      BEAT_DATA:   out_data.out_byte = new_r;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/sfcw_ctrl.sv
// Controller: RAM clear sweep, accept, compare and four-beat emit sequence.
// Depends on sfcw_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "shadow_framebuffer_change_writer_assert.svh"
module sfcw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  sfcw_pkg::dp_stat_t stat,
  output sfcw_pkg::ctl_cmd_t cmd,
  output logic               busy,
  output logic               out_valid
);
  import sfcw_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_CALC  = 7'b0000100,
    ST_EMIT0 = 7'b0001000,
    ST_EMIT1 = 7'b0010000,
    ST_EMIT2 = 7'b0100000,
    ST_EMIT3 = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.capture  = 1'b0;
    cmd.clr_step = 1'b0;
    cmd.commit   = 1'b0;
    cmd.beat     = BEAT_COL_LO;
    busy         = 1'b1;
    out_valid    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CALC;
        end
      end
      ST_CALC: begin
        // drop unchanged, out-of-range or invalid-command items without a beat
        if (stat.changed) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_EMIT0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT0: begin
        out_valid = 1'b1;
        cmd.beat  = BEAT_COL_LO;
        state_nxt = ST_EMIT1;
      end
      ST_EMIT1: begin
        out_valid = 1'b1;
        cmd.beat  = BEAT_COL_HI;
        state_nxt = ST_EMIT2;
      end
      ST_EMIT2: begin
        out_valid = 1'b1;
        cmd.beat  = BEAT_PAGE;
        state_nxt = ST_EMIT3;
      end
      ST_EMIT3: begin
        out_valid = 1'b1;
        cmd.beat  = BEAT_DATA;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `SFCW_ASSERT_IMPL(a_idle_quiet, clk, rst_n, !busy, !out_valid)
  `SFCW_ASSERT_NEXT(a_commit_emits, clk, rst_n, cmd.commit, out_valid && cmd.beat == BEAT_COL_LO)
  `SFCW_ASSERT_NEXT(a_run_ends, clk, rst_n, out_valid && cmd.beat == BEAT_DATA, !busy)
  `SFCW_ASSERT_NEXT(a_clear_done, clk, rst_n, state_r == ST_CLEAR && stat.clr_last, !busy)

endmodule
`default_nettype wire

FILE: rtl/shadow_framebuffer_change_writer.sv
// A changed byte is captured in ST_IDLE when start is taken, compared in ST_CALC after the
// registered read of the single-port shadow RAM, then emitted in ST_EMIT0 to ST_EMIT3 as four
// beats back to back. An item that changes nothing goes from ST_CALC back to ST_IDLE without a
// beat; busy stays high until the item is done, so a new item is taken only in ST_IDLE. Results
// cannot be stalled. After reset, busy stays high while the COLUMNS*PAGES bytes (1024 by
// default) of the shadow RAM are swept to 0x01. Depends on sfcw_pkg, sfcw_ctrl and sfcw_dp.
`timescale 1ns / 1ps
`default_nettype none
module shadow_framebuffer_change_writer #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  sfcw_pkg::in_t  in_data,
  output logic           out_valid,
  output sfcw_pkg::out_t out_data
);
  import sfcw_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  sfcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  sfcw_dp #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
